[hw/rtl/swin_pkg.sv]
package swin_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WINDOW_SIZE = 2'd0,
    CFG_DUP_LIMIT   = 2'd1
  } cfg_idx_e;

  // What the back end does with the packet store for one item
  typedef enum logic [1:0] {
    TX_NONE   = 2'd0,
    TX_NEW    = 2'd1,
    TX_RESEND = 2'd2
  } tx_kind_e;

  // Control flags handed from front to back through the queue
  typedef struct packed {
    logic     accepted;
    tx_kind_e tx_kind;
    logic     timer_stop;
    logic     timer_start;
  } swin_flags_t;

  localparam int FlagsW     = $bits(swin_flags_t);
  localparam int FifoDepth  = 2;
  localparam int WindowW    = 3;
  localparam int DupW       = 2;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 3;

endpackage

[hw/rtl/swin_front.sv]
module swin_front #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64,
  parameter int SeqW         = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config
  input  logic                            cfg_valid_i,
  input  logic [swin_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [swin_pkg::CfgDataW-1:0]   cfg_data_i,
  // incoming items
  input  logic                            in_valid_i,
  input  logic [1:0]                      operation_i,
  input  logic [PAYLOAD_BITS-1:0]         payload_i,
  input  logic [SeqW-1:0]                 ack_number_i,
  input  logic                            ack_checksum_ok_i,
  input  logic                            in_fire_i,
  // classified command
  output logic                            push_o,
  output swin_pkg::swin_flags_t           flags_o,
  output logic [SeqW-1:0]                 tx_seq_o,
  output logic [SeqW-1:0]                 timer_seq_o,
  output logic [PAYLOAD_BITS-1:0]         payload_o
);

  localparam logic [SeqW:0] SpaceW = (SeqW + 1)'(SEQ_SPACE);

  logic [swin_pkg::WindowW-1:0] window_size_q;
  logic [swin_pkg::DupW-1:0]    dup_limit_q;
  logic [SeqW-1:0]              base_q, base_d;
  logic [SeqW-1:0]              next_q, next_d;
  logic [swin_pkg::DupW-1:0]    dup_q, dup_d;

  logic [swin_pkg::WindowW-1:0] win_eff;
  logic [swin_pkg::DupW-1:0]    lim_eff;
  logic [SeqW-1:0]              win_red;
  logic [SeqW:0]                end_sum;
  logic [SeqW-1:0]              end_seq;
  logic                         full, empty, in_win;
  logic [swin_pkg::DupW-1:0]    dup_inc;
  swin_pkg::swin_flags_t        flags;
  logic [SeqW-1:0]              tx_seq;

  // window size modulo the sequence space; at most seven subtract steps
  function automatic logic [SeqW-1:0] reduce_win(logic [swin_pkg::WindowW-1:0] w);
    logic [3:0] v;
    v = {1'b0, w};
    for (int k = 0; k < 8; k++) begin
      if (32'(v) >= SEQ_SPACE) begin
        v = v - 4'(SEQ_SPACE % 16);
      end
    end
    return SeqW'(v);
  endfunction

  function automatic logic [SeqW-1:0] seq_inc(logic [SeqW-1:0] x);
    logic [SeqW:0] s;
    s = {1'b0, x} + (SeqW + 1)'(1);
    if (s >= SpaceW) begin
      s = s - SpaceW;
    end
    return SeqW'(s);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= swin_pkg::WindowW'(4);
      dup_limit_q   <= swin_pkg::DupW'(3);
    end else if (cfg_valid_i) begin
      unique case (swin_pkg::cfg_idx_e'(cfg_index_i))
        swin_pkg::CFG_WINDOW_SIZE: window_size_q <= cfg_data_i[swin_pkg::WindowW-1:0];
        swin_pkg::CFG_DUP_LIMIT:   dup_limit_q   <= cfg_data_i[swin_pkg::DupW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    win_eff = (window_size_q == '0) ? swin_pkg::WindowW'(1) : window_size_q;
    lim_eff = (dup_limit_q == '0) ? swin_pkg::DupW'(1) : dup_limit_q;
    win_red = reduce_win(win_eff);
    end_sum = {1'b0, base_q} + {1'b0, win_red};
    end_seq = (end_sum >= SpaceW) ? SeqW'(end_sum - SpaceW) : SeqW'(end_sum);
    full    = (end_seq == next_q);
    empty   = (base_q == next_q);
    if (end_seq > base_q) begin
      in_win = (ack_number_i >= base_q) && (ack_number_i < end_seq);
    end else if (end_seq < base_q) begin
      in_win = (ack_number_i >= base_q) || (ack_number_i < end_seq);
    end else begin
      in_win = 1'b0;
    end
    dup_inc = dup_q + swin_pkg::DupW'(1);
  end

  always_comb begin
    base_d = base_q;
    next_d = next_q;
    dup_d  = dup_q;
    flags  = '{accepted: 1'b0, tx_kind: swin_pkg::TX_NONE,
               timer_stop: 1'b0, timer_start: 1'b0};
    tx_seq = '0;
    unique case (operation_i)
      swin_pkg::OP_SEND: begin
        if (!full) begin
          flags.accepted    = 1'b1;
          flags.tx_kind     = swin_pkg::TX_NEW;
          flags.timer_start = empty;
          tx_seq            = next_q;
          next_d            = seq_inc(next_q);
        end
      end
      swin_pkg::OP_ACK: begin
        if (in_win && ack_checksum_ok_i) begin
          base_d            = seq_inc(ack_number_i);
          flags.timer_stop  = 1'b1;
          flags.timer_start = (base_d != next_q);
          dup_d             = '0;
        end else if (!in_win) begin
          dup_d = dup_inc;
          if (dup_inc == lim_eff) begin
            dup_d = '0;
            if (!empty) begin
              flags.timer_stop  = 1'b1;
              flags.timer_start = 1'b1;
              flags.tx_kind     = swin_pkg::TX_RESEND;
              tx_seq            = base_q;
            end
          end
        end
      end
      swin_pkg::OP_TIMEOUT: begin
        if (!empty) begin
          flags.timer_start = 1'b1;
          flags.tx_kind     = swin_pkg::TX_RESEND;
          tx_seq            = base_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      next_q <= '0;
      dup_q  <= '0;
    end else if (in_fire_i) begin
      base_q <= base_d;
      next_q <= next_d;
      dup_q  <= dup_d;
    end
  end

  assign push_o      = in_valid_i && in_fire_i;
  assign flags_o     = flags;
  assign tx_seq_o    = tx_seq;
  assign timer_seq_o = (flags.timer_stop || flags.timer_start) ? base_d : '0;
  assign payload_o   = payload_i;

  // a send that goes out always advances next_seq
  a_send_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && flags.tx_kind == swin_pkg::TX_NEW) |=> (next_q != $past(next_q)))
    else $error("accepted send did not advance next_seq");

endmodule

[hw/rtl/swin_fifo.sv]
module swin_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int Depth = swin_pkg::FifoDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (32'(p) == Depth - 1) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");

endmodule

[hw/rtl/swin_back.sv]
module swin_back #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64,
  parameter int SeqW         = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // from queue
  input  logic                    q_valid_i,
  input  swin_pkg::swin_flags_t   flags_i,
  input  logic [SeqW-1:0]         tx_seq_i,
  input  logic [SeqW-1:0]         timer_seq_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output logic                    pop_o,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    accepted_o,
  output logic                    tx_valid_o,
  output logic [SeqW-1:0]         tx_seq_o,
  output logic [PAYLOAD_BITS-1:0] tx_payload_o,
  output logic                    timer_stop_o,
  output logic                    timer_start_o,
  output logic [SeqW-1:0]         timer_seq_o
);

  logic [PAYLOAD_BITS-1:0] store_q [SEQ_SPACE];
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic                    valid_q;
  swin_pkg::swin_flags_t   flags_q;
  logic [SeqW-1:0]         seq_q, tseq_q;

  assign pop_o = q_valid_i && (!valid_q || out_ready_i);

  // packet store and payload stage, no reset
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      case (flags_i.tx_kind)
        swin_pkg::TX_NEW: begin
          store_q[tx_seq_i] <= payload_i;
          payload_q         <= payload_i;
        end
        swin_pkg::TX_RESEND: payload_q <= store_q[tx_seq_i];
        default:             payload_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flags_q <= '{accepted: 1'b0, tx_kind: swin_pkg::TX_NONE,
                   timer_stop: 1'b0, timer_start: 1'b0};
      seq_q   <= '0;
      tseq_q  <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      flags_q <= flags_i;
      seq_q   <= tx_seq_i;
      tseq_q  <= timer_seq_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = valid_q;
  assign accepted_o    = flags_q.accepted;
  assign tx_valid_o    = (flags_q.tx_kind != swin_pkg::TX_NONE);
  assign tx_seq_o      = seq_q;
  assign tx_payload_o  = payload_q;
  assign timer_stop_o  = flags_q.timer_stop;
  assign timer_start_o = flags_q.timer_start;
  assign timer_seq_o   = tseq_q;

  a_idle_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !tx_valid_o) |-> (seq_q == '0 && payload_q == '0))
    else $error("no packet sent but tx fields not zero");

  a_accept_is_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && flags_q.accepted) |-> (flags_q.tx_kind == swin_pkg::TX_NEW))
    else $error("accepted send without new transmission");

endmodule

[hw/rtl/sliding_window_sender.sv]
// Channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
// in       | in_valid_i / in_ready_o    | operation_i, payload_i, ack_number_i,
//          |                            | ack_checksum_ok_i
// out      | out_valid_o / out_ready_i  | accepted_o, tx_valid_o, tx_seq_o, tx_payload_o,
//          |                            | timer_stop_o, timer_start_o, timer_seq_o
//
// One item per cycle sustained unless the output stalls. A result is valid after its
//   input item is accepted and passes the queue entry, then the output register that
//   takes the packet store read.
// in_ready_o drops only when the 2-entry queue is full (output stalled).
// Reset: window_size 4, dup_ack_limit 3, base/next_seq/dup count 0. The packet store
//   is not cleared; config is always ready.
module sliding_window_sender #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64,
  localparam int SeqW        = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swin_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swin_pkg::CfgDataW-1:0] cfg_data_i,
  // event items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [PAYLOAD_BITS-1:0]       payload_i,
  input  logic [SeqW-1:0]               ack_number_i,
  input  logic                          ack_checksum_ok_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic                          tx_valid_o,
  output logic [SeqW-1:0]               tx_seq_o,
  output logic [PAYLOAD_BITS-1:0]       tx_payload_o,
  output logic                          timer_stop_o,
  output logic                          timer_start_o,
  output logic [SeqW-1:0]               timer_seq_o
);

  // queue entry: flags, tx seq, timer seq, payload
  localparam int EntryW = swin_pkg::FlagsW + 2 * SeqW + PAYLOAD_BITS;

  logic                    in_fire;
  logic                    q_ready, q_valid, push, pop;
  swin_pkg::swin_flags_t   f_flags, b_flags;
  logic [SeqW-1:0]         f_seq, f_tseq, b_seq, b_tseq;
  logic [PAYLOAD_BITS-1:0] f_payload, b_payload;
  logic [EntryW-1:0]       q_wdata, q_rdata;

  // config is taken any cycle; the user must write it only while idle (not enforced)
  assign cfg_ready_o = 1'b1;

  // front end accepts whenever the queue has room, independent of the output side
  assign in_ready_o = q_ready;
  assign in_fire    = in_valid_i && q_ready;

  // front: window bookkeeping and item classification
  swin_front #(
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SeqW         (SeqW)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .operation_i       (operation_i),
    .payload_i         (payload_i),
    .ack_number_i      (ack_number_i),
    .ack_checksum_ok_i (ack_checksum_ok_i),
    .in_fire_i         (in_fire),
    .push_o            (push),
    .flags_o           (f_flags),
    .tx_seq_o          (f_seq),
    .timer_seq_o       (f_tseq),
    .payload_o         (f_payload)
  );

  assign q_wdata = {f_flags, f_seq, f_tseq, f_payload};

  // short queue decoupling classification from the store access
  swin_fifo #(
    .WIDTH (EntryW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign {b_flags, b_seq, b_tseq, b_payload} = q_rdata;

  // back: packet store write / resend read and the result register
  swin_back #(
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SeqW         (SeqW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .flags_i       (b_flags),
    .tx_seq_i      (b_seq),
    .timer_seq_i   (b_tseq),
    .payload_i     (b_payload),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .tx_valid_o    (tx_valid_o),
    .tx_seq_o      (tx_seq_o),
    .tx_payload_o  (tx_payload_o),
    .timer_stop_o  (timer_stop_o),
    .timer_start_o (timer_start_o),
    .timer_seq_o   (timer_seq_o)
  );

endmodule

[tb/sv/sliding_window_sender_test.sv]
`timescale 1ns / 1ps

module sliding_window_sender_test;

  localparam int SeqW       = 3;
  localparam int PayW       = 64;
  localparam int QuietLimit = 2000;  // cycles with no handshake on any channel
  localparam int HoldCycles = 60;    // long receiver hold-off
  localparam int Latency    = 4;     // settle time after the last result

  // Codes the package leaves unnamed: the spare operation and register slots
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [PayW-1:0] payload;
    logic [SeqW-1:0] ack;
    logic            ck_ok;
  } swin_item_t;

  typedef struct packed {
    logic            accepted;
    logic            tx_valid;
    logic [SeqW-1:0] tx_seq;
    logic [PayW-1:0] tx_payload;
    logic            timer_stop;
    logic            timer_start;
    logic [SeqW-1:0] timer_seq;
  } swin_result_t;

  // Sender state plus its two config registers. 'written' marks store
  // entries filled since reset; the DUT store powers up unknown.
  typedef struct packed {
    logic [2:0]                win_cfg;
    logic [1:0]                dup_cfg;
    logic [SeqW-1:0]           base;
    logic [SeqW-1:0]           next;
    logic [1:0]                dups;
    logic [7:0]                written;
    logic [7:0][PayW-1:0]      store;
  } swin_state_t;

  // DUT connections; the inputs are all known from time zero
  logic            clk_i             = 1'b0;
  logic            rst_ni            = 1'b0;
  logic            cfg_valid_i       = 1'b0;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i       = '0;
  logic [2:0]      cfg_data_i        = '0;
  logic            in_valid_i        = 1'b0;
  logic            in_ready_o;
  logic [1:0]      operation_i       = '0;
  logic [PayW-1:0] payload_i         = '0;
  logic [SeqW-1:0] ack_number_i      = '0;
  logic            ack_checksum_ok_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i       = 1'b0;
  logic            accepted_o;
  logic            tx_valid_o;
  logic [SeqW-1:0] tx_seq_o;
  logic [PayW-1:0] tx_payload_o;
  logic            timer_stop_o;
  logic            timer_start_o;
  logic [SeqW-1:0] timer_seq_o;

  sliding_window_sender uut (.*);

  // Two copies of the sender: one steps as the generator plans items (so it
  // can steer clear of resending a never-written slot), one steps as the
  // DUT accepts them and produces the expected results.
  swin_state_t   sender_plan;
  swin_state_t   sender_now;
  swin_item_t    event_q[$];      // items waiting for the driver
  swin_result_t  due_results[$];  // predicted results, oldest first
  swin_item_t    driven_event;    // item currently on the input port

  bit          gaps_on;
  int          send_gap, recv_gap, hold_left;
  int          hold_req, hold_seen;
  int unsigned n_queued, n_accepted, n_checked, n_errors;
  int unsigned n_new, n_resend, n_refused, n_backpressure, quiet_cycles;

  initial forever #5 clk_i = ~clk_i;

  function automatic swin_state_t fresh_state();
    swin_state_t s;
    s         = '0;
    s.win_cfg = 3'd4;
    s.dup_cfg = 2'd3;
    return s;
  endfunction

  function automatic void set_reg(inout swin_state_t s, input logic [1:0] idx,
                                  input logic [2:0] data);
    if (idx == swin_pkg::CFG_WINDOW_SIZE) s.win_cfg = data;
    else if (idx == swin_pkg::CFG_DUP_LIMIT) s.dup_cfg = data[1:0];
  endfunction

  // One event through the sender; returns the result it produces.
  function automatic swin_result_t sender_step(inout swin_state_t s, input swin_item_t it);
    swin_result_t    r;
    logic [2:0]      win;
    logic [1:0]      lim;
    logic [SeqW-1:0] win_end;
    logic            in_win;
    r       = '0;
    win     = (s.win_cfg == 3'd0) ? 3'd1 : s.win_cfg;  // zero window acts as one
    lim     = (s.dup_cfg == 2'd0) ? 2'd1 : s.dup_cfg;  // zero limit acts as one
    win_end = s.base + win;                             // wraps in the seq space
    in_win  = SeqW'(it.ack - s.base) < win;
    case (it.op)
      swin_pkg::OP_SEND: begin
        if (win_end != s.next) begin
          s.store[s.next]   = it.payload;
          s.written[s.next] = 1'b1;
          r.accepted        = 1'b1;
          r.tx_valid        = 1'b1;
          r.tx_seq          = s.next;
          r.tx_payload      = it.payload;
          r.timer_start     = (s.base == s.next);
          s.next            = s.next + 1'b1;
        end
      end
      swin_pkg::OP_ACK: begin
        if (in_win && it.ck_ok) begin
          s.base        = it.ack + 1'b1;
          s.dups        = '0;
          r.timer_stop  = 1'b1;
          r.timer_start = (s.base != s.next);
        end else if (!in_win) begin
          s.dups = s.dups + 1'b1;
          if (s.dups == lim) begin
            s.dups = '0;
            if (s.base != s.next) begin  // fast retransmit of base
              r.timer_stop  = 1'b1;
              r.timer_start = 1'b1;
              r.tx_valid    = 1'b1;
              r.tx_seq      = s.base;
              r.tx_payload  = s.store[s.base];
            end
          end
        end
      end
      swin_pkg::OP_TIMEOUT: begin
        if (s.base != s.next) begin
          r.timer_start = 1'b1;
          r.tx_valid    = 1'b1;
          r.tx_seq      = s.base;
          r.tx_payload  = s.store[s.base];
        end
      end
      default: ;
    endcase
    if (r.timer_stop || r.timer_start) r.timer_seq = s.base;
    return r;
  endfunction

  function automatic string show(swin_result_t r);
    return $sformatf("acc=%0b tx=%0b seq=%0d data=%h stop=%0b start=%0b tseq=%0d",
                     r.accepted, r.tx_valid, r.tx_seq, r.tx_payload,
                     r.timer_stop, r.timer_start, r.timer_seq);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly well-formed traffic: sends, acks inside the outstanding range,
  // repeated acks of the last acked packet. The rest is noise.
  function automatic swin_item_t random_event(swin_state_t s);
    swin_item_t      it;
    logic [SeqW-1:0] in_flight;
    int              pick;
    it.op      = swin_pkg::OP_SEND;
    it.payload = {$urandom, $urandom};
    it.ack     = SeqW'($urandom_range(0, 7));
    it.ck_ok   = 1'b1;
    in_flight  = s.next - s.base;
    pick       = $urandom_range(0, 99);
    if (pick >= 45 && pick < 80) begin
      it.op = swin_pkg::OP_ACK;
      if (in_flight != 0 && pick < 68)
        it.ack = s.base + SeqW'($urandom_range(0, in_flight - 1));
      else if (pick < 74)
        it.ack = s.base - 1'b1;
      it.ck_ok = ($urandom_range(0, 9) != 0);
    end else if (pick >= 80 && pick < 95) begin
      it.op = swin_pkg::OP_TIMEOUT;
    end else if (pick >= 95) begin
      it.op = OP_RESERVED;
    end
    return it;
  endfunction

  // Plan an item; one that would resend a slot never written since reset
  // is turned into a send, which never reads the store.
  task automatic queue_event(input swin_item_t it);
    swin_state_t  trial;
    swin_result_t r;
    trial = sender_plan;
    r     = sender_step(trial, it);
    if (r.tx_valid && !r.accepted && !sender_plan.written[r.tx_seq])
      it.op = swin_pkg::OP_SEND;
    r = sender_step(sender_plan, it);
    event_q.push_back(it);
    n_queued++;
  endtask

  task automatic directed(input logic [1:0] op, input logic [PayW-1:0] payload,
                          input logic [SeqW-1:0] ack, input logic ck_ok);
    swin_item_t it;
    it = '{op: op, payload: payload, ack: ack, ck_ok: ck_ok};
    queue_event(it);
  endtask

  // Caller drops cfg_valid_i after the last write of a batch
  task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_reg(sender_now, idx, data);
    set_reg(sender_plan, idx, data);
  endtask

  // Sender pause: everything queued is accepted and every result is back
  task automatic drain();
    do @(posedge clk_i); while (n_accepted != n_queued || due_results.size() != 0);
    repeat (Latency) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    swin_result_t res;
    logic         free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      free = !in_valid_i;
      if (in_valid_i && !in_ready_o) n_backpressure++;
      if (in_valid_i && in_ready_o) begin
        res = sender_step(sender_now, driven_event);
        due_results.push_back(res);
        n_accepted++;
        if (res.accepted) n_new++;
        else if (res.tx_valid) n_resend++;
        else if (driven_event.op == swin_pkg::OP_SEND) n_refused++;
        free = 1'b1;
        if (gaps_on) send_gap = gap_len();
      end
      if (free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (event_q.size() != 0) begin
          driven_event       = event_q.pop_front();
          in_valid_i        <= 1'b1;
          operation_i       <= driven_event.op;
          payload_i         <= driven_event.payload;
          ack_number_i      <= driven_event.ack;
          ack_checksum_ok_i <= driven_event.ck_ok;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction and drives
  // out_ready_i with random gaps plus the requested long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    swin_result_t got, want;
    logic         rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {accepted_o, tx_valid_o, tx_seq_o, tx_payload_o,
               timer_stop_o, timer_start_o, timer_seq_o};
        if (due_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR unexpected result: %s", show(got));
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR result %0d: expected %s\n                 got      %s",
                       n_checked, show(want), show(got));
          end
        end
        n_checked++;
        if (gaps_on) recv_gap = gap_len();
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req != hold_seen) begin
        // long hold: the 2-deep queue fills and in_ready_o must drop
        hold_seen++;
        hold_left = HoldCycles;
        rdy       = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready_i <= rdy;
    end
  end

  // Watchdog: no handshake on any channel for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("ERROR: no progress for %0d cycles, %0d results outstanding",
               QuietLimit, due_results.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------
  logic [2:0] win_tab[5] = '{3'd1, 3'd7, 3'd0, 3'd3, 3'd5};
  logic [2:0] lim_tab[5] = '{3'd1, 3'd3, 3'd0, 3'b110, 3'd2};  // bit 2 is dropped

  initial begin
    sender_now  = fresh_state();
    sender_plan = fresh_state();
    gaps_on     = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, window 4, three duplicates to retransmit
    directed(swin_pkg::OP_TIMEOUT, '0, 3'd0, 1'b0);          // nothing outstanding
    directed(OP_RESERVED, '1, 3'd7, 1'b1);                   // unknown op, ignored
    directed(swin_pkg::OP_ACK, '0, 3'd5, 1'b1);              // out of window: dup 1
    directed(swin_pkg::OP_SEND, '1, 3'd0, 1'b0);             // seq 0, timer starts
    directed(swin_pkg::OP_SEND, '0, 3'd0, 1'b0);
    directed(swin_pkg::OP_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 1'b0);
    directed(swin_pkg::OP_SEND, 64'h5555_5555_5555_5555, 3'd0, 1'b0); // window now full
    directed(swin_pkg::OP_SEND, {$urandom, $urandom}, 3'd0, 1'b0);     // refused
    directed(swin_pkg::OP_ACK, '0, 3'd0, 1'b0);              // bad checksum, in window
    directed(swin_pkg::OP_ACK, '0, 3'd6, 1'b0);              // bad checksum, outside: dup 2
    directed(swin_pkg::OP_ACK, '0, 3'd7, 1'b1);              // dup 3: fast retransmit
    directed(swin_pkg::OP_TIMEOUT, '0, 3'd0, 1'b0);          // resend base
    directed(swin_pkg::OP_ACK, '0, 3'd1, 1'b1);              // base moves, timer restarts
    directed(swin_pkg::OP_ACK, '0, 3'd3, 1'b1);              // all acked: stop only
    directed(swin_pkg::OP_ACK, '0, 3'd4, 1'b1);              // ack past next_seq
    directed(swin_pkg::OP_SEND, {$urandom, $urandom}, 3'd0, 1'b0);
    repeat (4) directed(swin_pkg::OP_SEND, {$urandom, $urandom}, 3'd0, 1'b0);  // wraps
    directed(swin_pkg::OP_ACK, '0, 3'd7, 1'b1);              // window wraps too
    directed(swin_pkg::OP_ACK, '0, 3'd0, 1'b1);
    for (int a = 5; a < 8; a++)
      directed(swin_pkg::OP_ACK, '0, SeqW'(a), 1'b1);        // limit, none out
    drain();

    // Random phases, one config each, idle in between
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(swin_pkg::CFG_WINDOW_SIZE, win_tab[ph]);
      write_reg(swin_pkg::CFG_DUP_LIMIT, lim_tab[ph]);
      if (ph == 2) begin
        write_reg(CFG_SPARE_A, 3'd7);  // unmapped slots, no effect
        write_reg(CFG_SPARE_B, 3'd7);
      end
      cfg_valid_i <= 1'b0;
      gaps_on = (ph != 1);             // phase 1 runs back to back
      if (ph == 3) hold_req++;
      for (int n = 0; n < 100; n++) queue_event(random_event(sender_plan));
      drain();
    end

    $display("Ran %0d items over 6 window/limit settings: %0d new packets, %0d resends,",
             n_accepted, n_new, n_resend);
    $display("%0d refused sends, %0d results checked, input held off %0d cycles",
             n_refused, n_checked, n_backpressure);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
